// ===== sv/sxl_pkg.sv =====
// Package for the s-expression token lexer: sizes, result codes and the
// queue entry type shared by the front, queue and back modules.
// No dependencies.
package sxl_pkg;

  localparam int SYMBOL_LIMIT   = 32;
  localparam int TOKEN_CAPACITY = 64;
  localparam int POSITION_WIDTH = 16;

  localparam int STORE_DEPTH = SYMBOL_LIMIT - 1;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [63:0] SIGN_CAP = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    KIND_LPAREN = 3'd0,
    KIND_RPAREN = 3'd1,
    KIND_INT    = 3'd2,
    KIND_SYM    = 3'd3,
    KIND_ERROR  = 3'd4,
    KIND_END    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNEXPECTED = 2'd1,
    ERR_TOKEN_LONG = 2'd2,
    ERR_SYM_LONG   = 2'd3
  } err_e;

  // One queue entry: a single result, or a whole symbol burst.
  typedef struct packed {
    logic        is_sym;
    kind_e       kind;
    err_e        code;
    logic [31:0] int_value;
    logic [15:0] line;
    logic [15:0] column;
    logic [5:0]  sym_length;
    logic        last;
  } cmd_t;

  // Write port of the symbol character store.
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

  // Status from the back end to the front end.
  typedef struct packed {
    logic sym_done;
  } back_stat_t;

  // Largest magnitude that may still take digit d without passing 2^63.
  function automatic logic [63:0] dig_limit(input logic [3:0] d);
    logic [63:0] r;
    case (d)
      4'd0:    r = (SIGN_CAP - 64'd0) / 64'd10;
      4'd1:    r = (SIGN_CAP - 64'd1) / 64'd10;
      4'd2:    r = (SIGN_CAP - 64'd2) / 64'd10;
      4'd3:    r = (SIGN_CAP - 64'd3) / 64'd10;
      4'd4:    r = (SIGN_CAP - 64'd4) / 64'd10;
      4'd5:    r = (SIGN_CAP - 64'd5) / 64'd10;
      4'd6:    r = (SIGN_CAP - 64'd6) / 64'd10;
      4'd7:    r = (SIGN_CAP - 64'd7) / 64'd10;
      4'd8:    r = (SIGN_CAP - 64'd8) / 64'd10;
      default: r = (SIGN_CAP - 64'd9) / 64'd10;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/sxl_in_if.sv =====
// Request channel of the lexer: one source byte or end of text.
// No dependencies.
interface sxl_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] ch;

  modport source (output valid, req_type, ch, input ready);
  modport sink   (input valid, req_type, ch, output ready);
endinterface

// ===== sv/sxl_out_if.sv =====
// Result channel of the lexer: one token, symbol character, error or end.
// No dependencies.
interface sxl_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [1:0]         error_code;
  logic signed [31:0] int_value;
  logic [15:0]        line;
  logic [15:0]        column;
  logic [5:0]         sym_length;
  logic [5:0]         sym_index;
  logic [7:0]         sym_char;
  logic               token_end;
  logic               last;

  modport source (output valid, kind, error_code, int_value, line, column, sym_length,
                  sym_index, sym_char, token_end, last, input ready);
  modport sink   (input valid, kind, error_code, int_value, line, column, sym_length,
                  sym_index, sym_char, token_end, last, output ready);
endinterface

// ===== sv/sxl_front.sv =====
// Front end: takes requests, tracks the cursor and the pending token, and
// pushes up to two commands per request into the queue. Uses sxl_pkg.
module sxl_front import sxl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sxl_in_if.sink     req_i,
  input  logic       q_room_i,
  input  back_stat_t stat_i,
  output logic [1:0] push_n_o,
  output cmd_t       push0_o,
  output cmd_t       push1_o,
  output store_wr_t  store_wr_o
);

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  logic [POSITION_WIDTH-1:0] cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic [POSITION_WIDTH-1:0] st_line_q, st_line_d, st_col_q, st_col_d;
  logic [5:0]  tok_len_q, tok_len_d;
  logic [63:0] mag_q, mag_d;
  logic        neg_q, neg_d, saw_q, saw_d, num_q, num_d, failed_q, failed_d;
  logic        sym_busy_q, sym_busy_d;

  logic [POSITION_WIDTH-1:0] col_b;
  logic        acc, eot, has_tok, is_int, sym_err;
  logic        is_paren, is_ws, is_print;
  logic [3:0]  dig;
  logic [31:0] int_val;
  cmd_t        close_c, cmd_a, cmd_b;
  logic        va, vb;

  // Hold off while the queue lacks room or a symbol burst reads the store.
  assign req_i.ready = q_room_i && !sym_busy_q;
  assign acc = req_i.valid && req_i.ready;
  assign eot = req_i.req_type || (req_i.ch == 8'd0);

  assign col_b    = (cur_col_q != POS_MAX) ? cur_col_q + 1'b1 : cur_col_q;
  assign is_paren = (req_i.ch == "(") || (req_i.ch == ")");
  assign is_ws    = (req_i.ch == " ") || (req_i.ch >= 8'd9 && req_i.ch <= 8'd13);
  assign is_print = (req_i.ch > 8'd32) && (req_i.ch < 8'd127);
  assign dig      = 4'(req_i.ch - "0");

  assign has_tok = (tok_len_q != 6'd0);
  assign is_int  = num_q && saw_q;
  assign sym_err = !is_int && (tok_len_q >= 6'(SYMBOL_LIMIT));

  // Low word of the saturated signed value.
  assign int_val = neg_q ? (32'd0 - mag_q[31:0]) :
                   (mag_q[63] ? 32'hFFFF_FFFF : mag_q[31:0]);

  // Command that closes the pending token.
  always_comb begin
    close_c = '0;
    close_c.line   = st_line_q[15:0];
    close_c.column = st_col_q[15:0];
    if (is_int) begin
      close_c.kind      = KIND_INT;
      close_c.int_value = int_val;
    end else if (sym_err) begin
      close_c.kind = KIND_ERROR;
      close_c.code = ERR_SYM_LONG;
    end else begin
      close_c.is_sym     = 1'b1;
      close_c.kind       = KIND_SYM;
      close_c.sym_length = tok_len_q;
    end
  end

  // Request decode and token state update.
  always_comb begin
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    st_line_d  = st_line_q;
    st_col_d   = st_col_q;
    tok_len_d  = tok_len_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    saw_d      = saw_q;
    num_d      = num_q;
    failed_d   = failed_q;
    sym_busy_d = sym_busy_q && !stat_i.sym_done;
    cmd_a      = close_c;
    cmd_b      = '0;
    va         = 1'b0;
    vb         = 1'b0;
    store_wr_o = '0;

    if (acc) begin
      if (eot) begin
        va = !failed_q && has_tok;
        vb = 1'b1;
        cmd_b.kind   = KIND_END;
        cmd_b.line   = cur_line_q[15:0];
        cmd_b.column = cur_col_q[15:0];
        cur_line_d = POSITION_WIDTH'(1);
        cur_col_d  = '0;
        st_line_d  = POSITION_WIDTH'(1);
        st_col_d   = '0;
        failed_d   = 1'b0;
        tok_len_d  = '0;
        mag_d      = '0;
        neg_d      = 1'b0;
        saw_d      = 1'b0;
        num_d      = 1'b1;
      end else if (!failed_q) begin
        cur_col_d = col_b;
        if (is_paren || is_ws) begin
          va = has_tok;
          if (has_tok && sym_err) begin
            failed_d = 1'b1;
          end
          if (is_paren && !(has_tok && sym_err)) begin
            vb = 1'b1;
            cmd_b.kind   = (req_i.ch == "(") ? KIND_LPAREN : KIND_RPAREN;
            cmd_b.line   = cur_line_q[15:0];
            cmd_b.column = col_b[15:0];
          end
          if (req_i.ch == 8'd10) begin
            if (cur_line_q != POS_MAX) begin
              cur_line_d = cur_line_q + 1'b1;
            end
            cur_col_d = '0;
          end
          tok_len_d = '0;
          mag_d     = '0;
          neg_d     = 1'b0;
          saw_d     = 1'b0;
          num_d     = 1'b1;
        end else if (is_print && tok_len_q >= 6'(TOKEN_CAPACITY - 1)) begin
          va = 1'b1;
          cmd_a = '0;
          cmd_a.kind   = KIND_ERROR;
          cmd_a.code   = ERR_TOKEN_LONG;
          cmd_a.line   = st_line_q[15:0];
          cmd_a.column = st_col_q[15:0];
          failed_d  = 1'b1;
          tok_len_d = '0;
          mag_d     = '0;
          neg_d     = 1'b0;
          saw_d     = 1'b0;
          num_d     = 1'b1;
        end else if (is_print) begin
          if (!has_tok) begin
            st_line_d = cur_line_q;
            st_col_d  = col_b;
          end
          if (!has_tok && (req_i.ch == "+" || req_i.ch == "-")) begin
            neg_d = (req_i.ch == "-");
          end else if (req_i.ch >= "0" && req_i.ch <= "9") begin
            saw_d = 1'b1;
            if (mag_q > dig_limit(dig)) begin
              mag_d = SIGN_CAP;
            end else begin
              mag_d = (mag_q << 3) + (mag_q << 1) + 64'(dig);
            end
          end else begin
            num_d = 1'b0;
          end
          if (tok_len_q < 6'(STORE_DEPTH)) begin
            store_wr_o.we   = 1'b1;
            store_wr_o.addr = tok_len_q[STORE_AW-1:0];
            store_wr_o.data = req_i.ch;
          end
          tok_len_d = tok_len_q + 1'b1;
        end else begin
          va = 1'b1;
          cmd_a = '0;
          cmd_a.kind   = KIND_ERROR;
          cmd_a.code   = ERR_UNEXPECTED;
          cmd_a.line   = cur_line_q[15:0];
          cmd_a.column = col_b[15:0];
          failed_d  = 1'b1;
          tok_len_d = '0;
          mag_d     = '0;
          neg_d     = 1'b0;
          saw_d     = 1'b0;
          num_d     = 1'b1;
        end
      end
    end

    cmd_a.last = !vb;
    cmd_b.last = 1'b1;
    if (va && cmd_a.is_sym) begin
      sym_busy_d = 1'b1;
    end
  end

  // Pack the commands into the queue write slots.
  always_comb begin
    push_n_o = {1'b0, va} + {1'b0, vb};
    push0_o  = va ? cmd_a : cmd_b;
    push1_o  = cmd_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_line_q <= POSITION_WIDTH'(1);
      cur_col_q  <= '0;
      st_line_q  <= POSITION_WIDTH'(1);
      st_col_q   <= '0;
      tok_len_q  <= '0;
      mag_q      <= '0;
      neg_q      <= 1'b0;
      saw_q      <= 1'b0;
      num_q      <= 1'b1;
      failed_q   <= 1'b0;
      sym_busy_q <= 1'b0;
    end else begin
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      st_line_q  <= st_line_d;
      st_col_q   <= st_col_d;
      tok_len_q  <= tok_len_d;
      mag_q      <= mag_d;
      neg_q      <= neg_d;
      saw_q      <= saw_d;
      num_q      <= num_d;
      failed_q   <= failed_d;
      sym_busy_q <= sym_busy_d;
    end
  end

  // The magnitude never passes the saturation cap.
  a_mag_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= SIGN_CAP) else $error("magnitude above cap");
  // A failed lexer queues nothing for source bytes.
  a_failed_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && failed_q && !eot) |-> (push_n_o == 2'd0)) else $error("push while failed");
  // Token length stays below the capacity.
  a_tok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_len_q < 6'(TOKEN_CAPACITY - 1) || tok_len_q == 6'(TOKEN_CAPACITY - 1))
    else $error("token too long");

endmodule

// ===== sv/sxl_queue.sv =====
// Short command queue between the front and back ends; takes up to two
// entries per cycle and hands out at most one. Uses sxl_pkg.
module sxl_queue import sxl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  cmd_t       push0_i,
  input  cmd_t       push1_i,
  input  logic       pop_i,
  output logic       room_o,
  output logic       head_valid_o,
  output cmd_t       head_o
);

  cmd_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wptr_q, rptr_q;
  logic [QUEUE_AW:0]     cnt_q;
  logic [QUEUE_AW-1:0]   wptr1;

  assign wptr1        = wptr_q + 1'b1;
  assign room_o       = (cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wptr1] <= push1_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + QUEUE_AW'(push_n_i);
      rptr_q <= rptr_q + QUEUE_AW'(pop_i);
      cnt_q  <= cnt_q + (QUEUE_AW + 1)'(push_n_i) - (QUEUE_AW + 1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> room_o) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ===== sv/sxl_back.sv =====
// Back end: drains the command queue into the result register and walks
// the symbol store a character a cycle while not stalled. Uses sxl_pkg.
module sxl_back import sxl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  input  store_wr_t  store_wr_i,
  output logic       pop_o,
  output back_stat_t stat_o,
  sxl_out_if.source  res_o
);

  logic [7:0] store_q [STORE_DEPTH];
  logic [5:0] idx_q, idx_d;
  logic       load, sym_final;

  logic               valid_q;
  logic [2:0]         kind_q;
  logic [1:0]         code_q;
  logic signed [31:0] int_q;
  logic [15:0]        line_q, col_q;
  logic [5:0]         len_q, sidx_q;
  logic [7:0]         char_q;
  logic               tend_q, last_q;

  // Symbol character store.
  always_ff @(posedge clk_i) begin
    if (store_wr_i.we) begin
      store_q[store_wr_i.addr] <= store_wr_i.data;
    end
  end

  assign load      = head_valid_i && (!valid_q || res_o.ready);
  assign sym_final = (idx_q + 1'b1 == head_i.sym_length);

  // Burst sequencing and queue pop.
  always_comb begin
    idx_d           = idx_q;
    pop_o           = 1'b0;
    stat_o.sym_done = 1'b0;
    if (load) begin
      if (!head_i.is_sym) begin
        pop_o = 1'b1;
      end else if (sym_final) begin
        pop_o           = 1'b1;
        stat_o.sym_done = 1'b1;
        idx_d           = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.kind;
      code_q <= head_i.code;
      int_q  <= head_i.int_value;
      line_q <= head_i.line;
      col_q  <= head_i.column;
      len_q  <= head_i.sym_length;
      if (head_i.is_sym) begin
        sidx_q <= idx_q;
        char_q <= store_q[idx_q[STORE_AW-1:0]];
        tend_q <= sym_final;
        last_q <= sym_final && head_i.last;
      end else begin
        sidx_q <= '0;
        char_q <= '0;
        tend_q <= 1'b0;
        last_q <= head_i.last;
      end
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.kind       = kind_q;
  assign res_o.error_code = code_q;
  assign res_o.int_value  = int_q;
  assign res_o.line       = line_q;
  assign res_o.column     = col_q;
  assign res_o.sym_length = len_q;
  assign res_o.sym_index  = sidx_q;
  assign res_o.sym_char   = char_q;
  assign res_o.token_end  = tend_q;
  assign res_o.last       = last_q;

  // A burst index stays inside its symbol.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && head_i.is_sym) |-> (idx_q < head_i.sym_length))
    else $error("symbol index past length");
  // The counter is back at zero whenever no burst is under way.
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (idx_q == 6'd0)) else $error("stale burst index");
  // A held result is not overwritten.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_o.ready) |-> !load) else $error("result overwritten");

endmodule

// ===== sv/sexpr_token_lexer.sv =====
// S-expression token lexer: top level joining front end, queue and back end.
// Uses sxl_pkg, sxl_in_if, sxl_out_if, sxl_front, sxl_queue, sxl_back.
// Results pass through the command queue and then the result register after
// their request is taken. Throughput: one request and one result a cycle when
// the queue has room and the receiver is ready; a symbol gives one result per
// character, and the next request waits until its burst ends.
// Reset (asynchronous, active low) sets the cursor to line 1, column 0.
module sexpr_token_lexer import sxl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sxl_in_if.sink    req_i,
  sxl_out_if.source res_o
);

  logic       room, head_valid, pop;
  logic [1:0] push_n;
  cmd_t       push0, push1, head;
  store_wr_t  store_wr;
  back_stat_t stat;

  sxl_front u_front (
    .clk_i, .rst_ni, .req_i,
    .q_room_i(room), .stat_i(stat), .push_n_o(push_n),
    .push0_o(push0), .push1_o(push1), .store_wr_o(store_wr)
  );

  sxl_queue u_queue (
    .clk_i, .rst_ni, .push_n_i(push_n), .push0_i(push0), .push1_i(push1),
    .pop_i(pop), .room_o(room), .head_valid_o(head_valid), .head_o(head)
  );

  sxl_back u_back (
    .clk_i, .rst_ni, .head_valid_i(head_valid), .head_i(head),
    .store_wr_i(store_wr), .pop_o(pop), .stat_o(stat), .res_o
  );

endmodule

// ===== test/sxl_tb_pkg.sv =====
`timescale 1ns / 100ps
// Lexer behavior model for the token lexer testbench: cursor, token buffer and
// the result list that each request yields. Depends on sxl_pkg.
package sxl_tb_pkg;
  import sxl_pkg::*;

  typedef struct {
    kind_e       kind;
    err_e        code;
    logic [31:0] int_value;
    logic [15:0] line;
    logic [15:0] column;
    logic [5:0]  sym_length;
    logic [5:0]  sym_index;
    logic [7:0]  sym_char;
    logic        token_end;
    logic        last;
  } lex_result_t;

  localparam logic [31:0] POS_MAX = 32'((64'd1 << POSITION_WIDTH) - 1);

  // Lexer state as seen from outside.
  logic [31:0] cur_line, cur_col, tok_line, tok_col;
  int          tok_len;
  logic [7:0]  sym_buf [SYMBOL_LIMIT];
  logic [63:0] mag;
  logic        neg, have_digit, numeric, lex_failed;

  function automatic void clear_token();
    tok_len = 0;
    mag = '0;
    neg = 1'b0;
    have_digit = 1'b0;
    numeric = 1'b1;
  endfunction

  function automatic void lexer_reset();
    cur_line = 1;
    cur_col = 0;
    tok_line = 1;
    tok_col = 0;
    lex_failed = 1'b0;
    clear_token();
  endfunction

  function automatic void push(ref lex_result_t q[$], input kind_e k, input err_e c,
                               input logic [31:0] v, input logic [31:0] ln,
                               input logic [31:0] col, input int len = 0,
                               input int idx = 0, input logic [7:0] chr = 0,
                               input logic te = 0);
    lex_result_t r;
    r.kind = k;
    r.code = c;
    r.int_value = v;
    r.line = ln[15:0];
    r.column = col[15:0];
    r.sym_length = len[5:0];
    r.sym_index = idx[5:0];
    r.sym_char = chr;
    r.token_end = te;
    r.last = 1'b0;
    q.push_back(r);
  endfunction

  function automatic void raise_error(ref lex_result_t q[$], input err_e c,
                                      input logic [31:0] ln, input logic [31:0] col);
    push(q, KIND_ERROR, c, 0, ln, col);
    lex_failed = 1'b1;
    clear_token();
  endfunction

  // Emits the pending token; returns 0 when it turned out to be too long.
  function automatic bit flush_token(ref lex_result_t q[$]);
    logic [63:0] v;
    if (tok_len == 0) return 1;
    if (numeric && have_digit) begin
      if (neg) v = 64'd0 - mag;
      else v = (mag >= SIGN_CAP) ? SIGN_CAP - 1 : mag;
      push(q, KIND_INT, ERR_NONE, v[31:0], tok_line, tok_col);
    end else if (tok_len >= SYMBOL_LIMIT) begin
      raise_error(q, ERR_SYM_LONG, tok_line, tok_col);
      return 0;
    end else begin
      for (int i = 0; i < tok_len; i++)
        push(q, KIND_SYM, ERR_NONE, 0, tok_line, tok_col, tok_len, i, sym_buf[i],
             i + 1 == tok_len);
    end
    clear_token();
    return 1;
  endfunction

  function automatic void append_char(logic [7:0] c);
    logic [63:0] d;
    if (tok_len == 0) begin
      tok_line = cur_line;
      tok_col = cur_col;
    end
    if (tok_len == 0 && (c == "+" || c == "-")) begin
      neg = (c == "-");
    end else if (c >= "0" && c <= "9") begin
      d = c - "0";
      have_digit = 1'b1;
      if (mag > (SIGN_CAP - d) / 10) mag = SIGN_CAP;
      else mag = mag * 10 + d;
    end else begin
      numeric = 1'b0;
    end
    if (tok_len < SYMBOL_LIMIT - 1) sym_buf[tok_len] = c;
    tok_len++;
  endfunction

  // Results that one request causes, the last one flagged.
  function automatic void lex_request(input logic eot_req, input logic [7:0] c,
                                      ref lex_result_t q[$]);
    q.delete();
    if (eot_req || c == 0) begin
      if (!lex_failed) void'(flush_token(q));
      push(q, KIND_END, ERR_NONE, 0, cur_line, cur_col);
      lexer_reset();
    end else if (!lex_failed) begin
      if (cur_col < POS_MAX) cur_col++;
      if (c == "(" || c == ")") begin
        if (flush_token(q))
          push(q, c == "(" ? KIND_LPAREN : KIND_RPAREN, ERR_NONE, 0, cur_line, cur_col);
      end else if (c == " " || (c >= 9 && c <= 13)) begin
        if (c == 8'd10) begin
          if (cur_line < POS_MAX) cur_line++;
          cur_col = 0;
        end
        void'(flush_token(q));
      end else if (c > 32 && c < 127) begin
        if (tok_len >= TOKEN_CAPACITY - 1) raise_error(q, ERR_TOKEN_LONG, tok_line, tok_col);
        else append_char(c);
      end else begin
        raise_error(q, ERR_UNEXPECTED, cur_line, cur_col);
      end
    end
    if (q.size() > 0) q[q.size() - 1].last = 1'b1;
  endfunction
endpackage

// ===== test/sexpr_token_lexer_tb.sv =====
`timescale 1ns / 100ps
// Testbench for sexpr_token_lexer: directed and random source text, checked
// result by result against the lexer model. Depends on sxl_pkg and sxl_tb_pkg.
module sexpr_token_lexer_tb;
  import sxl_pkg::*;
  import sxl_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  sxl_in_if  req_if ();
  sxl_out_if res_if ();

  sexpr_token_lexer i_dut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .res_o(res_if));

  always #10 clk_i = ~clk_i;

  lex_result_t expected_q [$];
  int  mismatches = 0, requests_sent = 0, results_seen = 0, cycle_count = 0;
  bit  stall_enable = 1'b1;
  int  hold_off = 0;
  int  gap_max = 3;

  // Reports one mismatch.
  task automatic report(input string msg);
    mismatches++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Sends one request and records its expected results. The valid line stays
  // high into the next request unless a gap follows.
  task automatic send_req(input logic eot_req, input logic [7:0] c);
    lex_result_t r [$];
    req_if.valid <= 1'b1;
    req_if.req_type <= eot_req;
    req_if.ch <= c;
    do @(posedge clk_i); while (!req_if.ready);
    lex_request(eot_req, c, r);
    foreach (r[i]) expected_q.push_back(r[i]);
    requests_sent++;
    @(negedge clk_i);
    if (gap_max > 0 && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_req(1'b0, s[i]);
  endtask

  // Stops sending and waits until every expected result has come.
  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Receiver stall pattern, with an optional long hold-off.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !stall_enable || ($urandom_range(0, 9) > 2);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    lex_result_t e;
    cycle_count <= cycle_count + 1;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d", res_if.kind));
      end else begin
        e = expected_q.pop_front();
        if (res_if.kind !== e.kind || res_if.error_code !== e.code ||
            res_if.int_value !== e.int_value || res_if.line !== e.line ||
            res_if.column !== e.column || res_if.sym_length !== e.sym_length ||
            res_if.sym_index !== e.sym_index || res_if.sym_char !== e.sym_char ||
            res_if.token_end !== e.token_end || res_if.last !== e.last)
          report($sformatf({"got k%0d e%0d v%0h l%0d c%0d n%0d i%0d ch%0h te%0d la%0d,",
                            " want k%0d e%0d v%0h l%0d c%0d n%0d i%0d ch%0h te%0d la%0d"},
                 res_if.kind, res_if.error_code, res_if.int_value, res_if.line,
                 res_if.column, res_if.sym_length, res_if.sym_index, res_if.sym_char,
                 res_if.token_end, res_if.last, e.kind, e.code, e.int_value, e.line,
                 e.column, e.sym_length, e.sym_index, e.sym_char, e.token_end, e.last));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sexpr_token_lexer test failed");
      $finish;
    end
  end

  // Parentheses, integers at the saturation edges, signs and symbols.
  task automatic test_tokens();
    send_text("(+ -12 x)");
    send_req(1'b0, 8'd10);
    send_text("9223372036854775807 -9223372036854775808 99999999999999999999 -");
    send_text(" 2147483648 +7a");
    send_req(1'b1, 8'd0);
  endtask

  // Every error case, recovery through end of text, and zero byte as end.
  task automatic test_errors();
    send_text("ab");
    send_req(1'b0, 8'h80);
    send_text("zz");
    send_req(1'b0, 8'hFF);
    send_req(1'b0, 8'd0);
    send_req(1'b0, 8'd1);
    send_req(1'b1, 8'd0);
    repeat (SYMBOL_LIMIT) send_req(1'b0, "s");
    send_req(1'b0, ")");
    send_req(1'b1, 8'd0);
    repeat (SYMBOL_LIMIT - 1) send_req(1'b0, "q");
    send_req(1'b0, "(");
    repeat (TOKEN_CAPACITY) send_req(1'b0, "7");
    send_req(1'b1, 8'd0);
    repeat (SYMBOL_LIMIT) send_req(1'b0, "w");
    send_req(1'b1, 8'd0);
    send_req(1'b0, 8'h7F);
    send_req(1'b1, 8'hAA);
  endtask

  function automatic logic [7:0] rand_byte();
    int p = $urandom_range(0, 99);
    if (p < 25) return 8'("0" + $urandom_range(0, 9));
    if (p < 45) return 8'("a" + $urandom_range(0, 25));
    if (p < 55) return p[0] ? "(" : ")";
    if (p < 70) return $urandom_range(0, 3) == 0 ? 8'd10 : " ";
    if (p < 77) return p[0] ? "-" : "+";
    if (p < 96) return 8'($urandom_range(33, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  // Random well formed text with some noise, ended by end of text.
  task automatic test_random(input int n);
    int sent = 0;
    while (sent < n) begin
      gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      repeat ($urandom_range(5, 30)) begin
        send_req(1'b0, rand_byte());
        sent++;
      end
      send_req($urandom_range(0, 1), 8'd0);
      sent++;
    end
  endtask

  // Long receiver hold-off while requests keep coming, then a full drain.
  task automatic test_backpressure();
    hold_off = 200;
    gap_max = 0;
    send_text("(abcdefghij klmnop 123 -45 (x y z))");
    send_req(1'b1, 8'd0);
    wait_drain();
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.req_type = 1'b0;
    req_if.ch = 8'd0;
    res_if.ready = 1'b0;
    lexer_reset();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_tokens();
    test_errors();
    wait_drain();
    test_backpressure();
    stall_enable = 1'b0;
    test_random(10);
    stall_enable = 1'b1;
    test_random(20);
    wait_drain();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d requests and %0d results: tokens, errors, saturation, stalls.",
             requests_sent, results_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("sexpr_token_lexer test passed");
    end else begin
      $display("sexpr_token_lexer test failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/sxl_pkg.sv
sv/sxl_in_if.sv
sv/sxl_out_if.sv
sv/sxl_front.sv
sv/sxl_queue.sv
sv/sxl_back.sv
sv/sexpr_token_lexer.sv
test/sxl_tb_pkg.sv
test/sexpr_token_lexer_tb.sv
